// ===== sv/esc_pkg.sv =====
// esc_pkg: shared types, reciprocal constants and the month table for the
// epoch-seconds-to-calendar pipeline. Used by every module under sv/ but esc_checker.
`default_nettype none

package esc_pkg;

    // day split: v = epoch + 2^31 + DAY_REM_BIAS, days = DAY_BASE + v / 86400
    localparam logic [32:0] DAY_REM_BIAS = 33'd74752;
    localparam logic [17:0] DAY_BASE     = 18'd109918;

    // 86400 = 128 * 675, quotient by reciprocal 2^36 / 675 rounded up
    localparam logic [26:0] RECIP_675    = 27'd101806633;
    localparam int unsigned SHIFT_675    = 36;
    localparam logic [25:0] DIV_675      = 26'd675;

    // days per cycle, counted from 1601-01-01
    localparam logic [17:0] DAYS_400Y    = 18'd146097;
    localparam logic [17:0] DAYS_100Y_1  = 18'd36524;
    localparam logic [17:0] DAYS_100Y_2  = 18'd73048;
    localparam logic [17:0] DAYS_100Y_3  = 18'd109572;
    localparam logic [15:0] DAYS_4Y      = 16'd1461;
    localparam logic [10:0] DAYS_1Y_1    = 11'd365;
    localparam logic [10:0] DAYS_1Y_2    = 11'd730;
    localparam logic [10:0] DAYS_1Y_3    = 11'd1095;

    // quotient by 1461 for values below 2^16
    localparam logic [16:0] RECIP_1461   = 17'd91868;
    localparam int unsigned SHIFT_1461   = 27;

    // quotient by 7 for values below 2^18
    localparam logic [18:0] RECIP_7      = 19'd299594;
    localparam int unsigned SHIFT_7      = 21;

    // quotient by 60 for seconds of day (below 2^17) and minutes (below 2^11)
    localparam logic [17:0] RECIP_60_SOD = 18'd139811;
    localparam int unsigned SHIFT_60_SOD = 23;
    localparam logic [11:0] RECIP_60_MIN = 12'd2185;
    localparam int unsigned SHIFT_60_MIN = 17;

    localparam logic [10:0] BASE_YEAR    = 11'd1601;

    // cumulative days before each month, normal and leap years
    localparam logic [8:0] CUM_NORM [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };
    localparam logic [8:0] CUM_LEAP [13] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
        9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
    };

    // day number since 1601 and second of day
    typedef struct packed {
        logic [17:0] day_num;
        logic [16:0] sod;
    } day_t;

    // calendar fields before the month lookup
    typedef struct packed {
        logic [10:0] year;
        logic        leap_year;
        logic [8:0]  day_of_year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second_of_minute;
        logic [2:0]  weekday;
    } year_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day_of_month;
    } month_t;

    // month search over the cumulative table
    function automatic month_t month_lookup(input logic [8:0] yday, input logic leap);
        month_t     res;
        logic [3:0] m;
        logic [8:0] base;
        m = 4'd12;
        for (int k = 12; k >= 1; k--) begin
            if (yday < (leap ? CUM_LEAP[k] : CUM_NORM[k])) begin
                m = 4'(k);
            end
        end
        base = leap ? CUM_LEAP[m - 4'd1] : CUM_NORM[m - 4'd1];
        res.month = m;
        if (yday >= base) begin
            res.day_of_month = 5'(yday - base) + 5'd1;
        end else begin
            res.day_of_month = 5'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/esc_day_split.sv =====
// esc_day_split: two-stage split of the epoch count into a day number since
// 1601 and a second of day. Depends on esc_pkg.
`default_nettype none

module esc_day_split (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [31:0]    in_epoch,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output esc_pkg::day_t              out_day
);

    logic        v1_reg, v2_reg;
    logic        en1, en2;
    logic [16:0] dq_reg;
    logic [25:0] w_reg;
    logic [6:0]  lo_reg;
    esc_pkg::day_t day_reg;

    logic [32:0] v_next;
    logic [25:0] w_next;
    logic [52:0] prod_675;
    logic [16:0] dq_next;
    logic [25:0] rem_wide;
    esc_pkg::day_t day_next;

    // stage enables, back to front
    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: offset the count and take the quotient by 86400
    always_comb begin
        v_next   = {1'b0, ~in_epoch[31], in_epoch[30:0]} + esc_pkg::DAY_REM_BIAS;
        w_next   = v_next[32:7];
        prod_675 = 53'(w_next) * 53'(esc_pkg::RECIP_675);
        dq_next  = prod_675[52:esc_pkg::SHIFT_675];
    end

    // stage 2: remainder gives the second of day
    always_comb begin
        rem_wide         = w_reg - 26'(dq_reg) * esc_pkg::DIV_675;
        day_next.sod     = {rem_wide[9:0], lo_reg};
        day_next.day_num = esc_pkg::DAY_BASE + 18'(dq_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            dq_reg <= dq_next;
            w_reg  <= w_next;
            lo_reg <= v_next[6:0];
        end
        if (en2) begin
            day_reg <= day_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_day   = day_reg;

endmodule

`default_nettype wire

// ===== sv/esc_year_split.sv =====
// esc_year_split: four-stage removal of 400-, 100-, 4- and 1-year cycles,
// plus weekday and time of day. Depends on esc_pkg.
`default_nettype none

module esc_year_split (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire esc_pkg::day_t  in_day,
    output logic                out_valid,
    input  wire logic           out_ready,
    output esc_pkg::year_t      out_year
);

    logic v3_reg, v4_reg, v5_reg, v6_reg;
    logic en3, en4, en5, en6;

    // stage 3 registers
    logic        q400_3_reg;
    logic [1:0]  q100_3_reg;
    logic [15:0] r100_3_reg;
    logic [17:0] x_3_reg;
    logic [15:0] qw_3_reg;
    logic [16:0] sod_3_reg;
    logic [10:0] mt_3_reg;
    // stage 4 registers
    logic        q400_4_reg;
    logic [1:0]  q100_4_reg;
    logic [15:0] r100_4_reg;
    logic [4:0]  q4_4_reg;
    logic [2:0]  wday_4_reg;
    logic [5:0]  sec_4_reg;
    logic [10:0] mt_4_reg;
    logic [4:0]  hour_4_reg;
    // stage 5 registers
    logic        q400_5_reg;
    logic [1:0]  q100_5_reg;
    logic [4:0]  q4_5_reg;
    logic [10:0] r4_5_reg;
    logic [2:0]  wday_5_reg;
    logic [5:0]  sec_5_reg;
    logic [5:0]  min_5_reg;
    logic [4:0]  hour_5_reg;
    // stage 6 register
    esc_pkg::year_t year_reg;

    logic        ge400;
    logic [17:0] r400;
    logic [1:0]  q100_next;
    logic [17:0] r100_wide;
    logic [17:0] x_next;
    logic [36:0] prod_7;
    logic [34:0] prod_60s;
    logic [32:0] prod_1461;
    logic [22:0] prod_60m;
    logic [4:0]  q4_next;
    logic [4:0]  hour_next;
    logic [17:0] wday_wide;
    logic [16:0] sec_wide;
    logic [15:0] r4_wide;
    logic [10:0] min_wide;
    logic [1:0]  q1;
    logic [10:0] yday_wide;
    esc_pkg::year_t year_next;

    // stage enables, back to front
    assign en6      = !v6_reg || out_ready;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    // stage 3: 400- and 100-year cycles, products for weekday and minutes
    always_comb begin
        ge400     = in_day.day_num >= esc_pkg::DAYS_400Y;
        r400      = ge400 ? (in_day.day_num - esc_pkg::DAYS_400Y) : in_day.day_num;
        q100_next = 2'(r400 >= esc_pkg::DAYS_100Y_1) + 2'(r400 >= esc_pkg::DAYS_100Y_2)
                  + 2'(r400 >= esc_pkg::DAYS_100Y_3);
        unique case (q100_next)
            2'd0:    r100_wide = r400;
            2'd1:    r100_wide = r400 - esc_pkg::DAYS_100Y_1;
            2'd2:    r100_wide = r400 - esc_pkg::DAYS_100Y_2;
            default: r100_wide = r400 - esc_pkg::DAYS_100Y_3;
        endcase
        x_next   = in_day.day_num + 18'd1;
        prod_7   = 37'(x_next) * 37'(esc_pkg::RECIP_7);
        prod_60s = 35'(in_day.sod) * 35'(esc_pkg::RECIP_60_SOD);
    end

    // stage 4: 4-year quotient, weekday, seconds and hour
    always_comb begin
        prod_1461 = 33'(r100_3_reg) * 33'(esc_pkg::RECIP_1461);
        q4_next   = prod_1461[31:esc_pkg::SHIFT_1461];
        wday_wide = x_3_reg - 18'(qw_3_reg) * 18'd7;
        sec_wide  = sod_3_reg - 17'(mt_3_reg) * 17'd60;
        prod_60m  = 23'(mt_3_reg) * 23'(esc_pkg::RECIP_60_MIN);
        hour_next = prod_60m[21:esc_pkg::SHIFT_60_MIN];
    end

    // stage 5: days left in the 4-year cycle, minute of hour
    always_comb begin
        r4_wide  = r100_4_reg - 16'(q4_4_reg) * esc_pkg::DAYS_4Y;
        min_wide = mt_4_reg - 11'(hour_4_reg) * 11'd60;
    end

    // stage 6: single years, year number and leap flag
    always_comb begin
        q1 = 2'(r4_5_reg >= esc_pkg::DAYS_1Y_1) + 2'(r4_5_reg >= esc_pkg::DAYS_1Y_2)
           + 2'(r4_5_reg >= esc_pkg::DAYS_1Y_3);
        unique case (q1)
            2'd0:    yday_wide = r4_5_reg;
            2'd1:    yday_wide = r4_5_reg - esc_pkg::DAYS_1Y_1;
            2'd2:    yday_wide = r4_5_reg - esc_pkg::DAYS_1Y_2;
            default: yday_wide = r4_5_reg - esc_pkg::DAYS_1Y_3;
        endcase
        year_next.year = esc_pkg::BASE_YEAR + (q400_5_reg ? 11'd400 : 11'd0)
                       + 11'(q100_5_reg) * 11'd100 + {4'd0, q4_5_reg, 2'b00}
                       + 11'(q1);
        // last year of a 4-year cycle, except century years off the 400 mark
        year_next.leap_year        = (q1 == 2'd3) && ((q4_5_reg != 5'd24) || (q100_5_reg == 2'd3));
        year_next.day_of_year      = yday_wide[8:0];
        year_next.hour             = hour_5_reg;
        year_next.minute           = min_5_reg;
        year_next.second_of_minute = sec_5_reg;
        year_next.weekday          = wday_5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en3) v3_reg <= in_valid;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            q400_3_reg <= ge400;
            q100_3_reg <= q100_next;
            r100_3_reg <= r100_wide[15:0];
            x_3_reg    <= x_next;
            qw_3_reg   <= prod_7[36:esc_pkg::SHIFT_7];
            sod_3_reg  <= in_day.sod;
            mt_3_reg   <= prod_60s[33:esc_pkg::SHIFT_60_SOD];
        end
        if (en4) begin
            q400_4_reg <= q400_3_reg;
            q100_4_reg <= q100_3_reg;
            r100_4_reg <= r100_3_reg;
            q4_4_reg   <= q4_next;
            wday_4_reg <= wday_wide[2:0];
            sec_4_reg  <= sec_wide[5:0];
            mt_4_reg   <= mt_3_reg;
            hour_4_reg <= hour_next;
        end
        if (en5) begin
            q400_5_reg <= q400_4_reg;
            q100_5_reg <= q100_4_reg;
            q4_5_reg   <= q4_4_reg;
            r4_5_reg   <= r4_wide[10:0];
            wday_5_reg <= wday_4_reg;
            sec_5_reg  <= sec_4_reg;
            min_5_reg  <= min_wide[5:0];
            hour_5_reg <= hour_4_reg;
        end
        if (en6) begin
            year_reg <= year_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_year  = year_reg;

endmodule

`default_nettype wire

// ===== sv/esc_month.sv =====
// esc_month: final stage, month and day of month from the cumulative day
// table; also the output register of the core. Depends on esc_pkg.
`default_nettype none

module esc_month (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire esc_pkg::year_t  in_year,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output esc_pkg::year_t       out_year,
    output esc_pkg::month_t      out_month
);

    logic            v7_reg;
    logic            en7;
    esc_pkg::year_t  year_reg;
    esc_pkg::month_t month_reg;
    esc_pkg::month_t month_next;

    assign en7      = !v7_reg || out_ready;
    assign in_ready = en7;

    // table search on day of year
    always_comb begin
        month_next = esc_pkg::month_lookup(in_year.day_of_year, in_year.leap_year);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en7) begin
            v7_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en7) begin
            year_reg  <= in_year;
            month_reg <= month_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_year  = year_reg;
    assign out_month = month_reg;

endmodule

`default_nettype wire

// ===== sv/epoch_seconds_to_calendar_core.sv =====
// Epoch seconds to Gregorian calendar core: a signed 32-bit count of seconds
// since 1970-01-01 00:00:00 goes in, year, month, day, time of day, weekday
// (0 is Sunday), day of year and leap flag come out. The core is a 7-stage
// pipeline: a request is taken every cycle unless a full pipeline is held by
// an output stall; the stages run the chain of constant-reciprocal multiplies
// (day split, cycle quotients, time of day) and the month table stage. Each
// stage holds its own valid bit, so bubbles close up under output stall.
// Depends on esc_pkg, esc_day_split, esc_year_split and esc_month.
`default_nettype none

module epoch_seconds_to_calendar_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_epoch_seconds,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [10:0]             m_year,
    output logic [3:0]              m_month,
    output logic [4:0]              m_day_of_month,
    output logic [4:0]              m_hour,
    output logic [5:0]              m_minute,
    output logic [5:0]              m_second_of_minute,
    output logic [2:0]              m_weekday,
    output logic [8:0]              m_day_of_year,
    output logic                    m_leap_year
);

    logic            day_valid, day_ready;
    logic            yr_valid, yr_ready;
    esc_pkg::day_t   day;
    esc_pkg::year_t  yr;
    esc_pkg::year_t  out_yr;
    esc_pkg::month_t out_mon;

    // seconds to day number and second of day
    esc_day_split u_day_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_epoch  (s_epoch_seconds),
        .out_valid (day_valid),
        .out_ready (day_ready),
        .out_day   (day)
    );

    // year cycles, weekday, time of day
    esc_year_split u_year_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (day_valid),
        .in_ready  (day_ready),
        .in_day    (day),
        .out_valid (yr_valid),
        .out_ready (yr_ready),
        .out_year  (yr)
    );

    // month lookup and output register
    esc_month u_month (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (yr_valid),
        .in_ready  (yr_ready),
        .in_year   (yr),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_year  (out_yr),
        .out_month (out_mon)
    );

    assign m_year             = out_yr.year;
    assign m_month            = out_mon.month;
    assign m_day_of_month     = out_mon.day_of_month;
    assign m_hour             = out_yr.hour;
    assign m_minute           = out_yr.minute;
    assign m_second_of_minute = out_yr.second_of_minute;
    assign m_weekday          = out_yr.weekday;
    assign m_day_of_year      = out_yr.day_of_year;
    assign m_leap_year        = out_yr.leap_year;

endmodule

`default_nettype wire

// ===== sv/esc_checker.sv =====
// esc_checker: port-level checks for epoch_seconds_to_calendar_core, attached
// by the bind at the end of this file. Depends on the core's ports only.
`default_nettype none

module esc_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [10:0]        m_year,
    input wire logic [3:0]         m_month,
    input wire logic [4:0]         m_day_of_month,
    input wire logic [4:0]         m_hour,
    input wire logic [5:0]         m_minute,
    input wire logic [5:0]         m_second_of_minute,
    input wire logic [2:0]         m_weekday,
    input wire logic [8:0]         m_day_of_year,
    input wire logic               m_leap_year
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_year) && $stable(m_day_of_year)
            && $stable(m_hour) && $stable(m_minute) && $stable(m_second_of_minute))
        else $error("stalled result changed");

    // date fields in range
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month >= 4'd1) && (m_month <= 4'd12) && (m_day_of_month >= 5'd1)
            && (m_year >= 11'd1901) && (m_year <= 11'd2038))
        else $error("date field out of range");

    // time of day and weekday in range
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour < 5'd24) && (m_minute < 6'd60) && (m_second_of_minute < 6'd60)
            && (m_weekday < 3'd7))
        else $error("time field out of range");

    // only a leap year has a day 365, and leap years are multiples of four
    a_leap_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_leap_year || (m_day_of_year != 9'd365))
            && (!m_leap_year || (m_year[1:0] == 2'b00)))
        else $error("leap flag disagrees with year or day of year");

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (.*);

`default_nettype wire
